FILE: rtl/sos_pkg.sv
// ----------------------------------------------------------------------------
// sos_pkg
// Shared types, register indexes and helpers of the seek order scheduler.
// ----------------------------------------------------------------------------
package sos_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int TRACK_COUNT = 1024;

   localparam int TRACK_W    = 10;
   localparam int RSP_IDX_W  = 6;
   localparam int TOTAL_W    = 16;
   localparam int SUM_W      = 17;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;

   localparam logic [TRACK_W-1:0] TRACK_MAX =
      (TRACK_COUNT - 1 > 1023) ? 10'd1023 : TRACK_W'(TRACK_COUNT - 1);

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_POLICY  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCAN_UP = 2'd2;

   // policy codes
   localparam logic [1:0] POL_FIFO  = 2'd0;
   localparam logic [1:0] POL_SSTF  = 2'd1;
   localparam logic [1:0] POL_SCAN  = 2'd2;
   localparam logic [1:0] POL_CSCAN = 2'd3;

   typedef struct packed {
      logic [TRACK_W-1:0] track;
      logic               last_request;
   } req_type;

   typedef struct packed {
      logic [TRACK_W-1:0]   serviced_track;
      logic [RSP_IDX_W-1:0] request_index;
      logic [TRACK_W-1:0]   seek_step;
      logic [TOTAL_W-1:0]   total_distance;
      logic                 last_result;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;        // store the accepted request
      logic pass_init;   // head to start track, clear distance and result count
      logic scan_init;   // restart the walk over the batch
      logic scan_rd;     // read one stored track, advance the walk pointer
      logic emit;        // serve the best candidate into the output register
      logic finish;      // empty the batch
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_end;    // walk pointer is at the last stored request
      logic pass_end;    // the next result is the last of the pass
      logic out_free;    // output register can take a result this cycle
   } sts_type;

   function automatic logic [TRACK_W-1:0] sat_track(input logic [TRACK_W-1:0] v);
      return (v > TRACK_MAX) ? TRACK_MAX : v;
   endfunction

endpackage

FILE: rtl/sos_ctrl.sv
// ----------------------------------------------------------------------------
// sos_ctrl
// Sequencer: loads the batch, then per result walks the batch and serves one.
// ----------------------------------------------------------------------------
module sos_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_last,
   output logic             req_ready,
   input  sos_pkg::sts_type sts,
   output sos_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_PASS,
      ST_SCAN,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_last) begin
                  state_in = ST_PASS;
               end
            end
         end
         ST_PASS: begin
            cmd.pass_init = 1'b1;
            cmd.scan_init = 1'b1;
            state_in      = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (sts.scan_end) begin
               state_in = ST_DRAIN;
            end
         end
         // last read still in the compare stage
         ST_DRAIN: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.pass_end) begin
                  cmd.finish = 1'b1;
                  state_in   = ST_LOAD;
               end else begin
                  cmd.scan_init = 1'b1;
                  state_in      = ST_SCAN;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/sos_datapath.sv
// ----------------------------------------------------------------------------
// sos_datapath
// Track memory, served flags, candidate search, head and distance tracking.
// ----------------------------------------------------------------------------
module sos_datapath #(
   parameter int QUEUE_DEPTH = sos_pkg::QUEUE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  sos_pkg::cmd_type                    cmd,
   output sos_pkg::sts_type                    sts,
   input  sos_pkg::req_type                    req_data,
   input  logic                                csr_we,
   input  logic [sos_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sos_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output sos_pkg::rsp_type                    rsp_data
);

   localparam int IdxW   = $clog2(QUEUE_DEPTH);
   localparam int CntW   = $clog2(QUEUE_DEPTH + 1);
   localparam int TrkW   = sos_pkg::TRACK_W;
   localparam int SumW   = sos_pkg::SUM_W;
   localparam int TotW   = sos_pkg::TOTAL_W;
   localparam int RIdxW  = sos_pkg::RSP_IDX_W;
   localparam int RankW  = 17;

   // configuration
   logic [1:0]      policy_ff;
   logic [TrkW-1:0] start_ff;
   logic            scan_up_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff  <= sos_pkg::POL_SSTF;
         start_ff   <= '0;
         scan_up_ff <= 1'b1;
      end else if (csr_we) begin
         if (csr_index == sos_pkg::CSR_POLICY) begin
            policy_ff <= csr_wdata[1:0];
         end
         if (csr_index == sos_pkg::CSR_START) begin
            start_ff <= sos_pkg::sat_track(csr_wdata);
         end
         if (csr_index == sos_pkg::CSR_SCAN_UP) begin
            scan_up_ff <= csr_wdata[0];
         end
      end
   end

   // track memory
   logic [TrkW-1:0] track_mem [QUEUE_DEPTH];
   logic [TrkW-1:0] rd_track_ff;
   logic [CntW-1:0] count_ff;
   logic [IdxW-1:0] ptr_ff;
   logic            full;

   assign full = (count_ff == CntW'(QUEUE_DEPTH));

   always_ff @(posedge clock) begin
      if (cmd.load && !full) begin
         track_mem[count_ff[IdxW-1:0]] <= sos_pkg::sat_track(req_data.track);
      end
      if (cmd.scan_rd) begin
         rd_track_ff <= track_mem[ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.finish) begin
         count_ff <= '0;
      end else if (cmd.load && !full) begin
         count_ff <= count_ff + CntW'(1);
      end
   end

   // walk pointer and compare stage
   logic            cmp_vld_ff;
   logic [IdxW-1:0] cmp_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff     <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         cmp_vld_ff <= cmd.scan_rd;
         if (cmd.scan_init) begin
            ptr_ff <= '0;
         end else if (cmd.scan_rd) begin
            ptr_ff <= ptr_ff + IdxW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_rd) begin
         cmp_idx_ff <= ptr_ff;
      end
   end

   // head and pass state
   logic [TrkW-1:0] head_ff;
   logic [SumW-1:0] sum_ff;
   logic [IdxW-1:0] res_cnt_ff;
   logic [QUEUE_DEPTH-1:0] served_ff;

   function automatic logic [TrkW-1:0] abs_diff(input logic [TrkW-1:0] a,
                                                input logic [TrkW-1:0] b);
      return (a >= b) ? a - b : b - a;
   endfunction

   function automatic logic [RankW-1:0] rank_of(input logic [1:0]      pol,
                                                input logic            up,
                                                input logic [TrkW-1:0] t,
                                                input logic [TrkW-1:0] s,
                                                input logic [TrkW-1:0] head);
      logic [15:0] desc;
      logic [RankW-1:0] r;
      desc = 16'hFFFF - 16'(t);
      unique case (pol)
         sos_pkg::POL_FIFO: r = '0;
         sos_pkg::POL_SSTF: r = RankW'(abs_diff(head, t));
         sos_pkg::POL_SCAN: begin
            if (up) begin
               r = (t >= s) ? RankW'(t) : {1'b1, desc};
            end else begin
               r = (t <= s) ? {1'b0, desc} : {1'b1, 16'(t)};
            end
         end
         default: r = (t >= s) ? RankW'(t) : {1'b1, 16'(t)};
      endcase
      return r;
   endfunction

   // best candidate of the current walk
   logic             best_found_ff;
   logic [IdxW-1:0]  best_idx_ff;
   logic [TrkW-1:0]  best_track_ff;
   logic [RankW-1:0] best_rank_ff;
   logic [RankW-1:0] cand_rank;
   logic             take;

   assign cand_rank = rank_of(policy_ff, scan_up_ff, rd_track_ff, start_ff, head_ff);
   // strict less-than keeps the lowest index on equal rank
   assign take = cmp_vld_ff && !served_ff[cmp_idx_ff] &&
                 (!best_found_ff || cand_rank < best_rank_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         best_found_ff <= 1'b0;
      end else if (cmd.scan_init) begin
         best_found_ff <= 1'b0;
      end else if (take) begin
         best_found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         best_idx_ff   <= cmp_idx_ff;
         best_track_ff <= rd_track_ff;
         best_rank_ff  <= cand_rank;
      end
   end

   logic [TrkW-1:0] step;
   logic [SumW-1:0] sum_in;

   assign step   = abs_diff(head_ff, best_track_ff);
   assign sum_in = sum_ff + SumW'(step);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         sum_ff     <= '0;
         res_cnt_ff <= '0;
         served_ff  <= '0;
      end else begin
         if (cmd.pass_init) begin
            head_ff    <= start_ff;
            sum_ff     <= '0;
            res_cnt_ff <= '0;
         end else if (cmd.emit) begin
            head_ff    <= best_track_ff;
            sum_ff     <= sum_in;
            res_cnt_ff <= res_cnt_ff + IdxW'(1);
         end
         if (cmd.finish) begin
            served_ff <= '0;
         end else if (cmd.emit) begin
            served_ff[best_idx_ff] <= 1'b1;
         end
      end
   end

   // output register
   logic             rsp_valid_ff;
   sos_pkg::rsp_type rsp_data_ff;

   assign sts.out_free = !rsp_valid_ff || rsp_ready;
   assign sts.scan_end = (CntW'(ptr_ff) + CntW'(1)) == count_ff;
   assign sts.pass_end = (CntW'(res_cnt_ff) + CntW'(1)) == count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff.serviced_track <= best_track_ff;
         rsp_data_ff.request_index  <= RIdxW'(best_idx_ff);
         rsp_data_ff.seek_step      <= step;
         rsp_data_ff.total_distance <= sum_in[TotW-1:0];
         rsp_data_ff.last_result    <= sts.pass_end;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(QUEUE_DEPTH))
      else $error("batch count beyond queue depth");

   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.out_free)
      else $error("result served while output register is occupied");

   a_emit_unserved: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (best_found_ff && !served_ff[best_idx_ff]))
      else $error("served request is missing or already served");

   a_emit_in_batch: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (CntW'(best_idx_ff) < count_ff))
      else $error("served index outside the stored batch");

endmodule

FILE: rtl/seek_order_scheduler_core.sv
// ----------------------------------------------------------------------------
// seek_order_scheduler_core
// Disk head service-order scheduler (FIFO, SSTF, SCAN/LOOK, C-SCAN).
//
// Requests are loaded one per cycle into a track memory; the transaction
// flagged last_request starts a pass that returns one result per stored
// request in service order, then the batch is emptied. For each result the
// sequencer walks the whole batch through the single read port of the track
// memory, one stored request per cycle; a stall on the result side holds
// the pass. Requests are not taken during a pass; the final result may
// still wait in the output register while the next batch loads. A request
// beyond the queue depth is dropped. Configuration is sampled while a pass
// runs.
// ----------------------------------------------------------------------------
module seek_order_scheduler_core #(
   parameter int QUEUE_DEPTH = sos_pkg::QUEUE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  sos_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output sos_pkg::rsp_type               rsp_data,
   input  logic                           csr_we,
   input  logic [sos_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sos_pkg::CSR_DATA_W-1:0] csr_wdata
);

   sos_pkg::cmd_type cmd;
   sos_pkg::sts_type sts;

   sos_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last_request),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   sos_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
